### rtl/page_extent_allocator_macros.svh
// assertion helpers for the page extent allocator
`ifndef PAGE_EXTENT_ALLOCATOR_MACROS_SVH
`define PAGE_EXTENT_ALLOCATOR_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PEA_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define PEA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/pea_pkg.sv
package pea_pkg;

    localparam int MaxExtentsDef = 64;
    localparam int PageBitsDef   = 20;

    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StNoFit    = 3'd1;
    localparam logic [2:0] StFull     = 3'd2;
    localparam logic [2:0] StDupStart = 3'd3;
    localparam logic [2:0] StZero     = 3'd4;

endpackage

### rtl/page_extent_allocator.sv
// page extent allocator
// Channel: a transaction is taken when start is high and busy is low. Fields
// i_action (0 allocate, 1 free), i_start_page, i_page_count. The result
// appears on o_alloc_page and o_status for one cycle with o_done high; the
// receiver cannot stall it.
// Free extents live in one synchronous memory sorted by start page and are
// walked one entry at a time by a read-modify-write sequencer.
// Allocate: scan from entry 0 to the first fit; an exact fit then shifts the
// later entries down one at a time, and a larger fit is trimmed in place.
// Free: scan to the insert point, read both neighbors, then shift entries up
// or down one at a time as needed.
// The memory read port is the limit: one read per entry, each used in the
// cycle after it is issued.
// Reset (synchronous, active low) empties the table at once through the
// entry count; stored contents are not cleared and need no clearing pass.
`include "page_extent_allocator_macros.svh"
module page_extent_allocator
    import pea_pkg::*;
#(
    parameter int MAX_EXTENTS = MaxExtentsDef,
    parameter int PAGE_BITS   = PageBitsDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_action,
    input  logic [PAGE_BITS-1:0] i_start_page,
    input  logic [PAGE_BITS:0]   i_page_count,
    output logic                 o_done,
    output logic [19:0]          o_alloc_page,
    output logic [2:0]           o_status
);

    localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int PB = PAGE_BITS;
    localparam int DW = 2 * PB + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_ARD, S_ACHK, S_SRD, S_SWR, S_FRD, S_FCHK, S_LRD, S_LCHK,
        S_RRD, S_RCHK, S_UWR, S_URD, S_DONE
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_total;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_pos;
    logic              r_act;
    logic [PB-1:0]     r_sp;
    logic [PB:0]       r_cnt;
    logic [PB:0]       r_len;
    logic              r_left;
    logic [PB:0]       r_llen;
    logic [PB-1:0]     r_lsp;
    logic              r_down;
    logic              r_done;
    logic [19:0]       r_page;
    logic [2:0]        r_status;
    logic [DW-1:0]     r_hold;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [DW-1:0]     wdata, rdata;
    logic [PB-1:0]     rd_sp;
    logic [PB:0]       rd_len;
    logic [PB+1:0]     sum_l, sum_r;

    pea_table #(.MAX_EXTENTS(MAX_EXTENTS), .PAGE_BITS(PAGE_BITS)) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rd_sp  = rdata[DW-1:PB+1];
    assign rd_len = rdata[PB:0];
    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_alloc_page = r_page;
    assign o_status     = r_status;

    // memory address and write control
    always_comb begin
        we    = 1'b0;
        waddr = r_idx[AW-1:0];
        wdata = r_hold;
        raddr = r_idx[AW-1:0];
        unique case (r_state)
            S_ACHK: begin
                if (r_idx < r_total && rd_len > r_cnt) begin
                    we    = 1'b1;
                    wdata = {rd_sp, rd_len - r_cnt};
                end
            end
            S_SWR: begin
                we    = 1'b1;
                waddr = r_down ? AW'(r_idx - 1'b1) : AW'(r_idx + 1'b1);
                wdata = rdata;
            end
            S_UWR: begin
                we = 1'b1;
            end
            default: ;
        endcase
    end

    assign sum_l = {1'b0, r_lsp} + {1'b0, r_llen};
    assign sum_r = {2'b0, r_sp} + {1'b0, r_cnt};

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_act <= i_action;
                        r_sp  <= i_start_page;
                        r_cnt <= i_page_count;
                        r_idx <= '0;
                        r_left <= 1'b0;
                        r_down <= 1'b0;
                        if (i_page_count == '0) begin
                            r_page   <= '0;
                            r_status <= StZero;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= i_action ? S_FRD : S_ARD;
                        end
                    end
                end
                // allocate scan
                S_ARD: r_state <= S_ACHK;
                S_ACHK: begin
                    if (r_idx >= r_total) begin
                        r_page <= '0; r_status <= StNoFit; r_state <= S_DONE;
                    end else if (rd_len == r_cnt) begin
                        r_page   <= 20'(rd_sp);
                        r_status <= StOk;
                        r_down   <= 1'b1;
                        r_pos    <= r_total - 1'b1;
                        r_total  <= r_total - 1'b1;
                        r_idx    <= r_idx + 1'b1;
                        r_state  <= (r_idx + 1'b1 < r_total) ? S_SRD : S_DONE;
                    end else if (rd_len > r_cnt) begin
                        r_page   <= 20'(rd_sp + PB'(rd_len - r_cnt));
                        r_status <= StOk;
                        r_state  <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_ARD;
                    end
                end
                // shift one entry: read at r_idx, write to neighbor
                S_SRD: r_state <= S_SWR;
                S_SWR: begin
                    if (r_down) begin
                        if (r_idx + 1'b1 <= r_pos) begin
                            r_idx <= r_idx + 1'b1; r_state <= S_SRD;
                        end else r_state <= S_DONE;
                    end else begin
                        if (r_idx > r_pos) begin
                            r_idx <= r_idx - 1'b1; r_state <= S_SRD;
                        end else begin
                            r_hold  <= {r_sp, r_cnt};
                            r_state <= S_UWR;
                        end
                    end
                end
                // free: find first entry with start >= r_sp
                S_FRD: r_state <= S_FCHK;
                S_FCHK: begin
                    if (r_idx < r_total && rd_sp < r_sp) begin
                        r_lsp  <= rd_sp;
                        r_llen <= rd_len;
                        r_idx  <= r_idx + 1'b1;
                        r_state <= S_FRD;
                    end else if (r_idx < r_total && rd_sp == r_sp) begin
                        r_page <= '0; r_status <= StDupStart; r_state <= S_DONE;
                    end else begin
                        r_pos <= r_idx;
                        r_len <= r_cnt;
                        r_state <= S_LCHK;
                    end
                end
                S_LRD: r_state <= S_LCHK;
                S_LCHK: begin
                    if (r_pos != '0 && sum_l == {2'b0, r_sp}
                        && ({1'b0, r_llen} + {1'b0, r_cnt}) <= {1'b0, {(PB+1){1'b1}}}) begin
                        r_left <= 1'b1;
                        r_len  <= r_llen + r_cnt;
                    end
                    r_idx   <= r_pos;
                    r_state <= S_RRD;
                end
                S_RRD: r_state <= S_RCHK;
                S_RCHK: begin
                    r_page <= '0; r_status <= StOk;
                    if (r_pos < r_total && sum_r == {2'b0, rd_sp}
                        && ({1'b0, r_len} + {1'b0, rd_len}) <= {1'b0, {(PB+1){1'b1}}}) begin
                        if (r_left) begin
                            // both sides: grow left, drop right
                            r_hold  <= {r_lsp, r_len + rd_len};
                            r_idx   <= r_pos - 1'b1;
                            r_state <= S_URD;
                        end else begin
                            r_hold  <= {r_sp, r_len + rd_len};
                            r_state <= S_UWR;
                        end
                    end else if (r_left) begin
                        r_hold  <= {r_lsp, r_len};
                        r_idx   <= r_pos - 1'b1;
                        r_state <= S_UWR;
                    end else if (r_total >= CW'(MAX_EXTENTS)) begin
                        r_status <= StFull; r_state <= S_DONE;
                    end else begin
                        r_total <= r_total + 1'b1;
                        r_down  <= 1'b0;
                        if (r_total > r_pos) begin
                            r_idx   <= r_total - 1'b1;
                            r_state <= S_SRD;
                        end else begin
                            r_hold  <= {r_sp, r_cnt};
                            r_idx   <= r_pos;
                            r_state <= S_UWR;
                        end
                    end
                end
                // combined merge: write left, then shift the rest down
                S_URD: begin
                    r_down  <= 1'b1;
                    r_total <= r_total - 1'b1;
                    r_state <= S_UWR;
                end
                S_UWR: begin
                    if (r_down && r_left && r_act && r_pos < r_total + 1'b1
                        && r_idx + 1'b1 == r_pos && r_pos + 1'b1 <= r_total) begin
                        r_idx  <= r_pos + 1'b1;
                        r_pos  <= r_total;
                        r_left <= 1'b0;
                        r_state <= S_SRD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PEA_ASSERT(a_count_bound, r_total <= CW'(MAX_EXTENTS))
    `PEA_ASSERT_NEXT(a_done_one, r_done, !r_done)
    `PEA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `PEA_ASSERT(a_fail_page, !r_done || r_status == StOk || r_page == '0)

endmodule

### rtl/pea_table.sv
// extent table: one synchronous memory of start and length pairs
module pea_table
    import pea_pkg::*;
#(
    parameter int MAX_EXTENTS = MaxExtentsDef,
    parameter int PAGE_BITS   = PageBitsDef,
    localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1,
    localparam int DW = 2 * PAGE_BITS + 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [MAX_EXTENTS];
    logic [DW-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### bench/page_extent_allocator_tb.sv
`timescale 1ns / 1ps

module page_extent_allocator_tb
    import pea_pkg::*;
;

    localparam logic ActAlloc = 1'b0;
    localparam logic ActFree  = 1'b1;
    localparam int   NumExtents = 64;
    localparam int   RandomTxns = 950;
    localparam int   QuietTxns  = 150;
    localparam int   CycleLimit = 2000000;
    localparam longint unsigned LenMax = 64'h1F_FFFF;

    typedef struct packed {
        logic [19:0] page;
        logic [2:0]  status;
    } t_alloc_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_action;
    logic [19:0] i_start_page;
    logic [20:0] i_page_count;
    logic        o_done;
    logic [19:0] o_alloc_page;
    logic [2:0]  o_status;

    // free-extent table as the block should hold it
    logic [19:0] free_start[NumExtents];
    logic [20:0] free_len[NumExtents];
    int          free_count;

    t_alloc_result pending_results[$];
    int            error_count;
    int            cycle_count;
    bit            idle_enable;

    page_extent_allocator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_start_page (i_start_page),
        .i_page_count (i_page_count),
        .o_done       (o_done),
        .o_alloc_page (o_alloc_page),
        .o_status     (o_status)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("page_extent_allocator_tb: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // drop one table entry, closing the gap
    function automatic void drop_extent(input int idx);
        for (int i = idx; i + 1 < free_count; i++) begin
            free_start[i] = free_start[i + 1];
            free_len[i]   = free_len[i + 1];
        end
        free_count--;
    endfunction

    // expected response for one accepted transaction; updates the table
    function automatic t_alloc_result compute_allocation(input logic act,
            input logic [19:0] sp, input logic [20:0] cnt);
        t_alloc_result    res;
        longint unsigned  merged;
        longint unsigned  sum;
        int               pos;
        bit               join_lo;
        bit               join_hi;
        res = '0;
        if (cnt == 0) begin
            res.status = StZero;
        end else if (act == ActAlloc) begin
            res.status = StNoFit;
            for (int i = 0; i < free_count; i++) begin
                if (free_len[i] == cnt) begin
                    res.page   = free_start[i];
                    res.status = StOk;
                    drop_extent(i);
                    break;
                end
                if (free_len[i] > cnt) begin
                    free_len[i] = free_len[i] - cnt;
                    sum         = longint'(free_start[i]) + longint'(free_len[i]);
                    res.page    = sum[19:0];
                    res.status  = StOk;
                    break;
                end
            end
        end else begin
            pos = 0;
            while (pos < free_count && free_start[pos] < sp) pos++;
            if (pos < free_count && free_start[pos] == sp) begin
                res.status = StDupStart;
                return res;
            end
            join_lo = 0;
            join_hi = 0;
            merged  = cnt;
            if (pos > 0) begin
                if (longint'(free_start[pos-1]) + longint'(free_len[pos-1]) == longint'(sp) &&
                    longint'(free_len[pos-1]) + longint'(cnt) <= LenMax) begin
                    join_lo = 1;
                    merged  = longint'(free_len[pos-1]) + longint'(cnt);
                end
            end
            if (pos < free_count) begin
                if (longint'(sp) + longint'(cnt) == longint'(free_start[pos]) &&
                    merged + longint'(free_len[pos]) <= LenMax) begin
                    join_hi = 1;
                    merged  = merged + longint'(free_len[pos]);
                end
            end
            res.status = StOk;
            if (join_lo && join_hi) begin
                free_len[pos-1] = merged[20:0];
                drop_extent(pos);
            end else if (join_lo) begin
                free_len[pos-1] = merged[20:0];
            end else if (join_hi) begin
                free_start[pos] = sp;
                free_len[pos]   = merged[20:0];
            end else if (free_count >= NumExtents) begin
                res.status = StFull;
            end else begin
                for (int i = free_count; i > pos; i--) begin
                    free_start[i] = free_start[i-1];
                    free_len[i]   = free_len[i-1];
                end
                free_start[pos] = sp;
                free_len[pos]   = cnt;
                free_count++;
            end
        end
        return res;
    endfunction

    // one transaction: optional idle burst, then hold start until taken
    task automatic send_txn(input logic act, input logic [19:0] sp, input logic [20:0] cnt);
        @(posedge i_clk);
        if (idle_enable && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        start        <= 1'b1;
        i_action     <= act;
        i_start_page <= sp;
        i_page_count <= cnt;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(compute_allocation(act, sp, cnt));
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // response checker
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("response with no transaction outstanding");
            end else begin
                want = pending_results.pop_front();
                if (o_alloc_page !== want.page)
                    report_mismatch($sformatf("alloc_page %h, want %h",
                                              o_alloc_page, want.page));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_status, want.status));
            end
        end
    end

    // zero counts and allocation on an empty table
    task automatic test_zero_and_empty();
        send_txn(ActAlloc, 20'h0, 21'd0);
        send_txn(ActFree, 20'hFFFFF, 21'd0);
        send_txn(ActAlloc, 20'hFFFFF, 21'd1);
    endtask

    // inserts, merges on both sides, duplicate start, exact and larger fits
    task automatic test_merge_and_fit();
        send_txn(ActFree, 20'd100, 21'd10);
        send_txn(ActFree, 20'd120, 21'd10);
        send_txn(ActFree, 20'd100, 21'd3);
        send_txn(ActFree, 20'd110, 21'd10);
        send_txn(ActFree, 20'd90, 21'd10);
        send_txn(ActFree, 20'd130, 21'd5);
        send_txn(ActAlloc, 20'd0, 21'd7);
        send_txn(ActAlloc, 20'd0, 21'd38);
        send_txn(ActAlloc, 20'd0, 21'd1);
    endtask

    // large lengths, a duplicate start and an extent that runs past the top of the space
    task automatic test_limits();
        send_txn(ActFree, 20'd0, 21'h100000);
        send_txn(ActFree, 20'h0, 21'h100000);
        send_txn(ActFree, 20'hFFFFF, 21'h100000);
        send_txn(ActAlloc, 20'd0, 21'd5);
        send_txn(ActAlloc, 20'd0, 21'h100000);
        send_txn(ActAlloc, 20'd0, 21'h1FFFFF);
        wait_drained();
        while (free_count > 0) send_txn(ActAlloc, 20'd0, free_len[0]);
    endtask

    // fill all entries, overflow, then a merging free still succeeds
    task automatic test_table_full();
        int k;
        k = 0;
        while (free_count < NumExtents) begin
            send_txn(ActFree, 20'h80000 + 20'(4 * k), 21'd2);
            k++;
        end
        send_txn(ActFree, 20'h10, 21'd1);
        send_txn(ActFree, 20'h80002, 21'd1);
        send_txn(ActFree, 20'h80003, 21'd1);
        wait_drained();
        while (free_count > 0) send_txn(ActAlloc, 20'd0, free_len[0]);
    endtask

    // mostly well-formed traffic in a small window, some wide noise
    task automatic test_random_traffic();
        logic        act;
        logic [19:0] sp;
        logic [20:0] cnt;
        for (int n = 0; n < RandomTxns; n++) begin
            idle_enable = (n < RandomTxns - QuietTxns);
            act = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) < 8) begin
                sp  = 20'($urandom_range(0, 255) * 8);
                cnt = act ? 21'($urandom_range(1, 24)) : 21'($urandom_range(1, 32));
            end else begin
                sp = 20'($urandom_range(0, 20'hFFFFF));
                case ($urandom_range(0, 3))
                    0: cnt = 21'd0;
                    1: cnt = 21'h100000;
                    default: cnt = 21'($urandom_range(1, 21'h100000));
                endcase
            end
            send_txn(act, sp, cnt);
            if (n == RandomTxns / 2) wait_drained();
        end
    endtask

    initial begin
        error_count = 0;
        free_count  = 0;
        idle_enable = 1;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_action     <= ActAlloc;
        i_start_page <= '0;
        i_page_count <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_and_empty();
        test_merge_and_fit();
        test_limits();
        test_table_full();
        test_random_traffic();

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (error_count == 0)
            $display("page_extent_allocator_tb: clean");
        else
            $display("page_extent_allocator_tb: errors");
        $finish;
    end

endmodule
